// ===== rtl/sorted_timer_scheduler_macros.svh =====
// Assertion macros shared by the sorted timer scheduler RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef SORTED_TIMER_SCHEDULER_MACROS_SVH
`define SORTED_TIMER_SCHEDULER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define STS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true outside reset.
`define STS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== rtl/sts_pkg.sv =====
// Package for the sorted timer scheduler: widths, codes, payload structs,
// controller states and the command/status structs between control and datapath.
package sts_pkg;

  localparam int NumTimers = 16;
  localparam int TimerIdW  = 4;
  localparam int TimeW     = 48;
  localparam int OrdW      = 4;
  localparam int CntW      = 5;
  localparam int CfgW      = 24;
  localparam int CfgIdxW   = 1;
  localparam int OpW       = 3;
  localparam int KindW     = 2;
  localparam int ArCntW    = $clog2(TimeW);

  localparam logic [TimeW-1:0] MsUnits  = TimeW'(14112);
  localparam logic [CfgW-1:0]  TpsReset = CfgW'(320);
  localparam logic [CfgW-1:0]  BlkReset = CfgW'(20480);

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CfgTicksPerSample = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBlockTicks     = 1'b1;

  // Operation codes.
  localparam logic [OpW-1:0] OpArmAbs   = 3'd0;
  localparam logic [OpW-1:0] OpArmDelay = 3'd1;
  localparam logic [OpW-1:0] OpDisarm   = 3'd2;
  localparam logic [OpW-1:0] OpSetUnit  = 3'd3;
  localparam logic [OpW-1:0] OpTick     = 3'd4;

  // Result kinds.
  localparam logic [KindW-1:0] KindExpired = 2'd0;
  localparam logic [KindW-1:0] KindTickEnd = 2'd1;
  localparam logic [KindW-1:0] KindAck     = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]      op;
    logic [TimerIdW-1:0] timer_id;
    logic [TimeW-1:0]    value;
    logic                sample_based;
  } sts_in_t;

  typedef struct packed {
    logic [KindW-1:0]    kind;
    logic [TimerIdW-1:0] expired_id;
    logic [TimeW-1:0]    time_now;
    logic                last;
  } sts_out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_USZ, ST_USZ_W, ST_MUL, ST_MUL_W, ST_ARM, ST_DISARM,
    ST_NU, ST_NU_W, ST_NUCMP, ST_DIV, ST_DIV_W, ST_SETU, ST_ACK,
    ST_TNEXT, ST_SCAN, ST_TPICK, ST_TDIS, ST_TEMIT, ST_TDONE
  } sts_state_e;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_LOAD_VAL, ACT_US_RAW, ACT_US_RES, ACT_T_RES, ACT_ARM,
    ACT_DISARM, ACT_NU_RAW, ACT_NU_RES, ACT_REM, ACT_ACC_RES, ACT_SETU,
    ACT_TNEXT, ACT_SCAN, ACT_TPICK, ACT_TDIS
  } sts_act_e;

  // Operand routing for the shared multiply/divide unit.
  typedef enum logic [1:0] {
    ARS_USZ, ARS_NU, ARS_MUL, ARS_DIV
  } sts_arsel_e;

  typedef struct packed {
    logic             latch;
    sts_act_e         act;
    logic             ar_start;
    sts_arsel_e       ar_sel;
    logic             emit;
    logic [KindW-1:0] kind;
  } sts_cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           in_samp;
    logic           usamp;
    logic           same_unit;
    logic           rem_pos;
    logic           armed_id;
    logic           ar_done;
    logic           scan_last;
    logic           found;
    logic           out_free;
  } sts_stat_t;

endpackage

// ===== rtl/sts_arith.sv =====
// Shared iterative unit: saturating 48x48 shift-add multiply or restoring divide.
// One bit per cycle. Depends on sts_pkg.
module sts_arith (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     div_i,
  input  logic [sts_pkg::TimeW-1:0] a_i,
  input  logic [sts_pkg::TimeW-1:0] b_i,
  output logic                     done_o,
  output logic [sts_pkg::TimeW-1:0] result_o
);

  localparam int W = sts_pkg::TimeW;

  logic [W-1:0]                 hi_q, hi_d, lo_q, lo_d, op_q;
  logic                         div_q, busy_q, done_q;
  logic [sts_pkg::ArCntW-1:0]   cnt_q;
  logic [W:0]                   msum, rsh;
  logic [W+1:0]                 diff;
  logic                         ge;

  // One iteration of either algorithm.
  always_comb begin
    msum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, op_q} : '0);
    rsh  = {hi_q, lo_q[W-1]};
    diff = {1'b0, rsh} - {2'b00, op_q};
    ge   = !diff[W+1];
    if (div_q) begin
      hi_d = ge ? diff[W-1:0] : rsh[W-1:0];
      lo_d = {lo_q[W-2:0], ge};
    end else begin
      hi_d = msum[W:1];
      lo_d = {msum[0], lo_q[W-1:1]};
    end
  end

  // Control of the iteration count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == sts_pkg::ArCntW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= div_i;
      hi_q  <= '0;
      lo_q  <= div_i ? a_i : b_i;
      op_q  <= div_i ? b_i : a_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = (!div_q && hi_q != '0) ? '1 : lo_q;

endmodule

// ===== rtl/sts_ctrl.sv =====
// Controller state machine of the sorted timer scheduler.
// Sequences the datapath through sts_cmd_t; depends on sts_pkg.
module sts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sts_pkg::sts_stat_t stat_i,
  output sts_pkg::sts_cmd_t  cmd_o
);

  sts_pkg::sts_state_e state_q, state_d;
  logic                phase_q, phase_d;
  sts_pkg::sts_state_e after_usz;

  // After the unit size is known: multiply for delays and re-arming, else divide.
  assign after_usz = (stat_i.op == sts_pkg::OpArmDelay || phase_q) ?
                     sts_pkg::ST_MUL : sts_pkg::ST_DIV;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sts_pkg::ST_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      sts_pkg::ST_IDLE:   if (in_valid_i) state_d = sts_pkg::ST_DECODE;
      sts_pkg::ST_DECODE: begin
        phase_d = 1'b0;
        unique case (stat_i.op)
          sts_pkg::OpArmAbs:   state_d = sts_pkg::ST_ARM;
          sts_pkg::OpArmDelay: state_d = sts_pkg::ST_USZ;
          sts_pkg::OpDisarm:   state_d = sts_pkg::ST_DISARM;
          sts_pkg::OpSetUnit:  state_d = sts_pkg::ST_NU;
          sts_pkg::OpTick:     state_d = sts_pkg::ST_TNEXT;
          default:             state_d = sts_pkg::ST_ACK;
        endcase
      end
      sts_pkg::ST_USZ:    state_d = stat_i.usamp ? sts_pkg::ST_USZ_W : after_usz;
      sts_pkg::ST_USZ_W:  if (stat_i.ar_done) state_d = after_usz;
      sts_pkg::ST_MUL:    state_d = sts_pkg::ST_MUL_W;
      sts_pkg::ST_MUL_W:  if (stat_i.ar_done) state_d = sts_pkg::ST_ARM;
      sts_pkg::ST_ARM:    state_d = sts_pkg::ST_ACK;
      sts_pkg::ST_DISARM: state_d = sts_pkg::ST_ACK;
      sts_pkg::ST_NU:     state_d = stat_i.in_samp ? sts_pkg::ST_NUCMP : sts_pkg::ST_NU_W;
      sts_pkg::ST_NU_W:   if (stat_i.ar_done) state_d = sts_pkg::ST_NUCMP;
      sts_pkg::ST_NUCMP: begin
        if (stat_i.same_unit) state_d = sts_pkg::ST_ACK;
        else if (stat_i.rem_pos) state_d = sts_pkg::ST_USZ;
        else state_d = sts_pkg::ST_SETU;
      end
      sts_pkg::ST_DIV:    state_d = sts_pkg::ST_DIV_W;
      sts_pkg::ST_DIV_W:  if (stat_i.ar_done) state_d = sts_pkg::ST_SETU;
      sts_pkg::ST_SETU: begin
        if (stat_i.armed_id) begin
          phase_d = 1'b1;
          state_d = sts_pkg::ST_USZ;
        end else begin
          state_d = sts_pkg::ST_ACK;
        end
      end
      sts_pkg::ST_ACK:    if (stat_i.out_free) state_d = sts_pkg::ST_IDLE;
      sts_pkg::ST_TNEXT:  state_d = sts_pkg::ST_SCAN;
      sts_pkg::ST_SCAN:   if (stat_i.scan_last) state_d = sts_pkg::ST_TPICK;
      sts_pkg::ST_TPICK:  state_d = stat_i.found ? sts_pkg::ST_TDIS : sts_pkg::ST_TDONE;
      sts_pkg::ST_TDIS:   state_d = sts_pkg::ST_TEMIT;
      sts_pkg::ST_TEMIT:  if (stat_i.out_free) state_d = sts_pkg::ST_SCAN;
      sts_pkg::ST_TDONE:  if (stat_i.out_free) state_d = sts_pkg::ST_IDLE;
      default:            state_d = sts_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o          = '0;
    cmd_o.act      = sts_pkg::ACT_NONE;
    cmd_o.ar_sel   = sts_pkg::ARS_USZ;
    cmd_o.kind     = sts_pkg::KindAck;
    in_ready_o     = 1'b0;
    unique case (state_q)
      sts_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      sts_pkg::ST_DECODE: cmd_o.act = sts_pkg::ACT_LOAD_VAL;
      sts_pkg::ST_USZ: begin
        if (stat_i.usamp) cmd_o.ar_start = 1'b1;
        else cmd_o.act = sts_pkg::ACT_US_RAW;
      end
      sts_pkg::ST_USZ_W:  if (stat_i.ar_done) cmd_o.act = sts_pkg::ACT_US_RES;
      sts_pkg::ST_MUL: begin
        cmd_o.ar_start = 1'b1;
        cmd_o.ar_sel   = sts_pkg::ARS_MUL;
      end
      sts_pkg::ST_MUL_W:  if (stat_i.ar_done) cmd_o.act = sts_pkg::ACT_T_RES;
      sts_pkg::ST_ARM:    cmd_o.act = sts_pkg::ACT_ARM;
      sts_pkg::ST_DISARM: cmd_o.act = sts_pkg::ACT_DISARM;
      sts_pkg::ST_NU: begin
        if (stat_i.in_samp) begin
          cmd_o.act = sts_pkg::ACT_NU_RAW;
        end else begin
          cmd_o.ar_start = 1'b1;
          cmd_o.ar_sel   = sts_pkg::ARS_NU;
        end
      end
      sts_pkg::ST_NU_W:   if (stat_i.ar_done) cmd_o.act = sts_pkg::ACT_NU_RES;
      sts_pkg::ST_NUCMP:  if (!stat_i.same_unit) cmd_o.act = sts_pkg::ACT_REM;
      sts_pkg::ST_DIV: begin
        cmd_o.ar_start = 1'b1;
        cmd_o.ar_sel   = sts_pkg::ARS_DIV;
      end
      sts_pkg::ST_DIV_W:  if (stat_i.ar_done) cmd_o.act = sts_pkg::ACT_ACC_RES;
      sts_pkg::ST_SETU:   cmd_o.act = sts_pkg::ACT_SETU;
      sts_pkg::ST_ACK: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = sts_pkg::KindAck;
      end
      sts_pkg::ST_TNEXT:  cmd_o.act = sts_pkg::ACT_TNEXT;
      sts_pkg::ST_SCAN:   cmd_o.act = sts_pkg::ACT_SCAN;
      sts_pkg::ST_TPICK:  cmd_o.act = sts_pkg::ACT_TPICK;
      sts_pkg::ST_TDIS:   cmd_o.act = sts_pkg::ACT_TDIS;
      sts_pkg::ST_TEMIT: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = sts_pkg::KindExpired;
      end
      sts_pkg::ST_TDONE: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = sts_pkg::KindTickEnd;
      end
      default: cmd_o.act = sts_pkg::ACT_NONE;
    endcase
  end

endmodule

// ===== rtl/sts_dpath.sv =====
// Datapath of the sorted timer scheduler: timer table, time, config, scan and
// output register. Depends on sts_pkg, sts_arith and the assertion macros.
`include "sorted_timer_scheduler_macros.svh"

module sts_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sts_pkg::sts_cmd_t           cmd_i,
  output sts_pkg::sts_stat_t          stat_o,
  input  sts_pkg::sts_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output sts_pkg::sts_out_t           out_data_o,
  input  logic                        cfg_we_i,
  input  logic [sts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sts_pkg::CfgW-1:0]    cfg_wdata_i
);

  localparam int W  = sts_pkg::TimeW;
  localparam int N  = sts_pkg::NumTimers;
  localparam int IW = sts_pkg::TimerIdW;

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[W] ? '1 : s[W-1:0];
  endfunction

  // Timer table.
  logic [W-1:0]              dl_q [N];
  logic [W-1:0]              ut_q [N];
  logic [N-1:0]              armed_q, usamp_q;
  logic [sts_pkg::OrdW-1:0]  ord_q [N];
  logic [sts_pkg::CntW-1:0]  cnt_q;

  // Time, configuration and work registers.
  logic [W-1:0]              cur_q, next_q, acc_q, us_q, nu_q, best_dl_q;
  logic [sts_pkg::CfgW-1:0]  tps_q, blk_q;
  logic [sts_pkg::OpW-1:0]   op_q;
  logic [IW-1:0]             id_q, idx_q, best_q, rd_idx;
  logic [W-1:0]              val_q;
  logic                      samp_q, found_q;
  logic [sts_pkg::OrdW-1:0]  best_ord_q;
  logic                      out_valid_q;
  sts_pkg::sts_out_t         out_q;

  logic [W-1:0]              rd_dl, rd_ut, v1, ar_a, ar_b, ar_res, t_arm;
  logic [sts_pkg::OrdW-1:0]  rd_ord;
  logic                      rd_armed, rd_usamp, ar_div, ar_done, cand, out_free;
  logic [sts_pkg::CfgW-1:0]  tps_eff;
  logic [sts_pkg::CntW-1:0]  cnt_after;
  logic                      dis_en, arm_en;

  // Single read port into the table: scan index while scanning, else addressed timer.
  assign rd_idx   = (cmd_i.act == sts_pkg::ACT_SCAN) ? idx_q : id_q;
  assign rd_dl    = dl_q[rd_idx];
  assign rd_ut    = ut_q[rd_idx];
  assign rd_ord   = ord_q[rd_idx];
  assign rd_armed = armed_q[rd_idx];
  assign rd_usamp = usamp_q[rd_idx];

  assign v1        = (val_q == '0) ? W'(1) : val_q;
  assign tps_eff   = (tps_q == '0) ? sts_pkg::CfgW'(1) : tps_q;
  assign cnt_after = cnt_q - (rd_armed ? sts_pkg::CntW'(1) : '0);
  assign t_arm     = (acc_q < cur_q) ? cur_q : acc_q;
  assign dis_en    = (cmd_i.act == sts_pkg::ACT_DISARM) || (cmd_i.act == sts_pkg::ACT_TDIS);
  assign arm_en    = (cmd_i.act == sts_pkg::ACT_ARM);
  assign out_free  = !out_valid_q || out_ready_i;

  // A timer beats the best so far by earlier deadline, then by older arming.
  assign cand = rd_armed && (rd_dl < next_q) &&
                (!found_q || rd_dl < best_dl_q ||
                 (rd_dl == best_dl_q && rd_ord < best_ord_q));

  // Operand routing for the shared unit.
  always_comb begin
    ar_div = 1'b0;
    unique case (cmd_i.ar_sel)
      sts_pkg::ARS_USZ: begin
        ar_a = rd_ut;
        ar_b = W'(tps_eff);
      end
      sts_pkg::ARS_NU: begin
        ar_a = v1;
        ar_b = sts_pkg::MsUnits;
      end
      sts_pkg::ARS_MUL: begin
        ar_a = us_q;
        ar_b = acc_q;
      end
      default: begin
        ar_a   = acc_q;
        ar_b   = us_q;
        ar_div = 1'b1;
      end
    endcase
  end

  sts_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.ar_start),
    .div_i    (ar_div),
    .a_i      (ar_a),
    .b_i      (ar_b),
    .done_o   (ar_done),
    .result_o (ar_res)
  );

  // Timer table, arming order and armed count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      usamp_q <= '0;
      cnt_q   <= '0;
      for (int j = 0; j < N; j++) begin
        dl_q[j]  <= '0;
        ut_q[j]  <= sts_pkg::MsUnits;
        ord_q[j] <= '0;
      end
    end else begin
      if ((dis_en || arm_en) && rd_armed) begin
        // Close the gap in the arming order left by the removed timer.
        for (int j = 0; j < N; j++) begin
          if (armed_q[j] && ord_q[j] > rd_ord) ord_q[j] <= ord_q[j] - 1'b1;
        end
      end
      if (dis_en) begin
        armed_q[id_q] <= 1'b0;
        ord_q[id_q]   <= '0;
        cnt_q         <= cnt_after;
      end
      if (arm_en) begin
        dl_q[id_q]    <= t_arm;
        armed_q[id_q] <= 1'b1;
        ord_q[id_q]   <= cnt_after[sts_pkg::OrdW-1:0];
        cnt_q         <= cnt_after + 1'b1;
      end
      if (cmd_i.act == sts_pkg::ACT_SETU) begin
        ut_q[id_q]    <= nu_q;
        usamp_q[id_q] <= samp_q;
      end
    end
  end

  // Time, configuration, scan control and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      tps_q       <= sts_pkg::TpsReset;
      blk_q       <= sts_pkg::BlkReset;
      found_q     <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sts_pkg::CfgTicksPerSample: tps_q <= cfg_wdata_i;
          default:                    blk_q <= cfg_wdata_i;
        endcase
      end
      unique case (cmd_i.act)
        sts_pkg::ACT_TNEXT, sts_pkg::ACT_TDIS: begin
          idx_q   <= '0;
          found_q <= 1'b0;
        end
        sts_pkg::ACT_SCAN: begin
          idx_q <= idx_q + 1'b1;
          if (cand) found_q <= 1'b1;
        end
        sts_pkg::ACT_TPICK: cur_q <= found_q ? best_dl_q : next_q;
        default: ;
      endcase
      if (cmd_i.emit && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload and work registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= in_data_i.op;
      id_q   <= in_data_i.timer_id;
      val_q  <= in_data_i.value;
      samp_q <= in_data_i.sample_based;
    end
    unique case (cmd_i.act)
      sts_pkg::ACT_LOAD_VAL: acc_q <= val_q;
      sts_pkg::ACT_US_RAW:   us_q  <= rd_ut;
      sts_pkg::ACT_US_RES:   us_q  <= ar_res;
      sts_pkg::ACT_T_RES:    acc_q <= sat_add(cur_q, ar_res);
      sts_pkg::ACT_NU_RAW:   nu_q  <= v1;
      sts_pkg::ACT_NU_RES:   nu_q  <= ar_res;
      sts_pkg::ACT_REM:      acc_q <= (rd_armed && rd_dl > cur_q) ? rd_dl - cur_q : '0;
      sts_pkg::ACT_ACC_RES:  acc_q <= ar_res;
      sts_pkg::ACT_TNEXT:    next_q <= sat_add(cur_q, W'(blk_q));
      sts_pkg::ACT_SCAN: begin
        if (cand) begin
          best_q     <= idx_q;
          best_dl_q  <= rd_dl;
          best_ord_q <= rd_ord;
        end
      end
      sts_pkg::ACT_TPICK:    if (found_q) id_q <= best_q;
      default: ;
    endcase
    if (cmd_i.emit && out_free) begin
      out_q.kind       <= cmd_i.kind;
      out_q.expired_id <= (cmd_i.kind == sts_pkg::KindTickEnd) ? '0 : id_q;
      out_q.time_now   <= cur_q;
      out_q.last       <= (cmd_i.kind != sts_pkg::KindExpired);
    end
  end

  // Status to the controller.
  always_comb begin
    stat_o.op        = op_q;
    stat_o.in_samp   = samp_q;
    stat_o.usamp     = rd_usamp;
    stat_o.same_unit = (samp_q == rd_usamp) && (nu_q == rd_ut);
    stat_o.rem_pos   = rd_armed && (rd_dl > cur_q);
    stat_o.armed_id  = rd_armed;
    stat_o.ar_done   = ar_done;
    stat_o.scan_last = (idx_q == IW'(N - 1));
    stat_o.found     = found_q;
    stat_o.out_free  = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The armed count tracks the armed flags.
  `STS_ASSERT(a_cnt_matches, (cnt_q == $countones(armed_q)), "armed count mismatch")
  // An arm leaves the addressed timer armed.
  `STS_ASSERT(a_arm_sets, ((cmd_i.act == sts_pkg::ACT_ARM) |=> armed_q[$past(id_q)]), "arm lost")
  // The best candidate of a scan always lies before the tick target.
  `STS_ASSERT_NEVER(a_best_late, (found_q && best_dl_q >= next_q), "best beyond tick")

endmodule

// ===== rtl/sorted_timer_scheduler.sv =====
// Sorted one-shot timer table. A tick runs one scan pass per expired timer plus a final
// one; every pass scans the 16 timers.
// It takes one operation at a time; the bit-serial arithmetic unit and the scan set its pace.
// Reset (rst_ni low, asynchronous): all timers disarmed, units one millisecond, time zero.
// Top level; depends on sts_pkg, sts_ctrl and sts_dpath.
module sorted_timer_scheduler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  sts_pkg::sts_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output sts_pkg::sts_out_t           out_data_o,
  input  logic                        cfg_we_i,
  input  logic [sts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sts_pkg::CfgW-1:0]    cfg_wdata_i
);

  sts_pkg::sts_cmd_t  cmd;
  sts_pkg::sts_stat_t stat;

  sts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sts_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule
